/* design/bpas_pkg.sv */
// shared constants and payload types of the bit packed array store
package bpas_pkg;

  localparam int unsigned STORE_WORDS = 1024;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned SHIFT_W     = $clog2(WORD_BITS);
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned INDEX_W     = 15;
  localparam int unsigned START_W     = INDEX_W + CFG_W;
  localparam int unsigned ROW_W       = ($clog2(STORE_WORDS) > 1) ? $clog2(STORE_WORDS) - 1 : 1;
  localparam int unsigned WORD_W      = ROW_W + 1;
  localparam int unsigned BANK_DEPTH  = (STORE_WORDS + 1) / 2;
  localparam int unsigned STORE_BITS  = STORE_WORDS * WORD_BITS;

  localparam logic [CFG_W-1:0] BPI_RESET = CFG_W'(8);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [INDEX_W-1:0]   item_index;
    logic [WORD_BITS-1:0] write_value;
    logic                 run_end;
  } req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_value;
    logic                 index_error;
    logic                 last_of_run;
  } rsp_t;

endpackage

/* design/bpas_intf.sv */
// handshake channels of the bit packed array store
interface bpas_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bpas_pkg::CFG_W-1:0]  bits_per_item;
  modport source (output valid, output bits_per_item, input ready);
  modport sink (input valid, input bits_per_item, output ready);
endinterface

interface bpas_req_if;
  logic           valid;
  logic           ready;
  bpas_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpas_rsp_if;
  logic           valid;
  logic           ready;
  bpas_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/bpas_ram.sv */
// generic single write port ram with registered read
module bpas_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bit_packed_array_store_unit.sv */
// bit packed array store: an accepted request reads both word banks, then the modify state loads the output register
// one request in flight at a time, held by the read then write back of the word banks
// a response waits in an output register; the next request is taken while it waits
// reset: async active low, then a clearing pass over all BANK_DEPTH rows (512 by default)
// zeroes both banks with the request channel not ready; config writes are taken throughout
module bit_packed_array_store_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  bpas_cfg_if.sink        cfg_i,
  bpas_req_if.sink        req_i,
  bpas_rsp_if.source      rsp_o
);

  localparam int unsigned ROW_W     = bpas_pkg::ROW_W;
  localparam int unsigned WORD_W    = bpas_pkg::WORD_W;
  localparam int unsigned START_W   = bpas_pkg::START_W;
  localparam int unsigned CFG_W     = bpas_pkg::CFG_W;
  localparam int unsigned SHIFT_W   = bpas_pkg::SHIFT_W;
  localparam int unsigned WORD_BITS = bpas_pkg::WORD_BITS;
  localparam int unsigned DBL_BITS  = 2 * WORD_BITS;

  // sequencer codes
  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_MODIFY = 2'd2;

  localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(bpas_pkg::BANK_DEPTH - 1);
  localparam logic [START_W:0]   STORE_END  = (START_W + 1)'(bpas_pkg::STORE_BITS);
  localparam logic [CFG_W-1:0]   WIDTH_MAX  = CFG_W'(WORD_BITS);

  logic [1:0]           state_q, state_d;
  logic [ROW_W-1:0]     clear_row_q;
  logic [CFG_W-1:0]     bpi_q;

  // item context captured at accept
  logic                 odd_q;
  logic [ROW_W-1:0]     row_q;
  logic [SHIFT_W-1:0]   shift_q;
  logic [CFG_W-1:0]     width_q;
  logic                 err_q;
  logic                 kind_q;
  logic [WORD_BITS-1:0] wval_q;
  logic                 last_q;

  // output register
  logic                 out_valid_q;
  bpas_pkg::rsp_t       out_q;

  // config channel is always open; the user must write only while idle, the block does not enforce it
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpi_q <= bpas_pkg::BPI_RESET;
    end else if (cfg_i.valid) begin
      bpi_q <= cfg_i.bits_per_item;
    end
  end

  // address generation at accept
  logic                 req_fire;
  logic [CFG_W-1:0]     width_eff;
  logic [START_W-1:0]   start_bit;
  logic [START_W:0]     end_bit;
  logic [WORD_W-1:0]    word_idx;
  logic [ROW_W-1:0]     row_idx;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    // width zero acts as one, anything past a word acts as a full word
    if (bpi_q == '0) begin
      width_eff = CFG_W'(1);
    end else if (bpi_q > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = bpi_q;
    end
  end

  assign start_bit = START_W'(req_i.data.item_index) * START_W'(width_eff);
  assign end_bit   = (START_W + 1)'(start_bit) + (START_W + 1)'(width_eff);
  assign word_idx  = start_bit[SHIFT_W +: WORD_W];
  assign row_idx   = word_idx[WORD_W-1:1];

  // even words live in bank 0, odd words in bank 1, so the two words of a
  // spanning item always sit in different banks
  logic                 b0_we, b1_we;
  logic [ROW_W-1:0]     b0_waddr, b1_waddr;
  logic [WORD_BITS-1:0] b0_wdata, b1_wdata;
  logic [ROW_W-1:0]     b0_raddr;
  logic [WORD_BITS-1:0] b0_rdata, b1_rdata;

  assign b0_raddr = word_idx[0] ? row_idx + ROW_W'(1) : row_idx;

  // read-modify-write in the modify state
  logic                 out_free;
  logic                 do_load;
  logic                 do_write;
  logic                 spans;
  logic [WORD_BITS-1:0] lo_word, hi_word;
  logic [DBL_BITS-1:0]  both, mask, merged, read_bits;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign do_load  = (state_q == ST_MODIFY) && out_free;
  assign do_write = do_load && !err_q && (kind_q == bpas_pkg::KIND_WRITE);

  assign spans     = ((SHIFT_W + 2)'(shift_q) + (SHIFT_W + 2)'(width_q)) >
                     (SHIFT_W + 2)'(WORD_BITS);
  assign lo_word   = odd_q ? b1_rdata : b0_rdata;
  assign hi_word   = odd_q ? b0_rdata : b1_rdata;
  assign both      = {hi_word, lo_word};
  assign mask      = (DBL_BITS'(1) << width_q) - DBL_BITS'(1);
  assign read_bits = (both >> shift_q) & mask;
  assign merged    = (both & ~(mask << shift_q)) |
                     ((DBL_BITS'(wval_q) & mask) << shift_q);

  always_comb begin
    if (state_q == ST_CLEAR) begin
      b0_we    = 1'b1;
      b1_we    = 1'b1;
      b0_waddr = clear_row_q;
      b1_waddr = clear_row_q;
      b0_wdata = '0;
      b1_wdata = '0;
    end else begin
      // bank 0 takes the high word when the item starts on an odd word
      b0_we    = do_write && (!odd_q || spans);
      b1_we    = do_write && (odd_q || spans);
      b0_waddr = odd_q ? row_q + ROW_W'(1) : row_q;
      b1_waddr = row_q;
      b0_wdata = odd_q ? merged[DBL_BITS-1:WORD_BITS] : merged[WORD_BITS-1:0];
      b1_wdata = odd_q ? merged[WORD_BITS-1:0] : merged[DBL_BITS-1:WORD_BITS];
    end
  end

  bpas_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (bpas_pkg::BANK_DEPTH)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (b0_we),
    .waddr_i (b0_waddr),
    .wdata_i (b0_wdata),
    .re_i    (req_fire),
    .raddr_i (b0_raddr),
    .rdata_o (b0_rdata)
  );

  bpas_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (bpas_pkg::BANK_DEPTH)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (b1_we),
    .waddr_i (b1_waddr),
    .wdata_i (b1_wdata),
    .re_i    (req_fire),
    .raddr_i (row_idx),
    .rdata_o (b1_rdata)
  );

  // sequencer: clearing pass, then accept / modify
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clear_row_q == LAST_ROW) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clear_row_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clear_row_q <= clear_row_q + ROW_W'(1);
      end
      if (do_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item context, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      odd_q   <= word_idx[0];
      row_q   <= row_idx;
      shift_q <= start_bit[SHIFT_W-1:0];
      width_q <= width_eff;
      err_q   <= end_bit > STORE_END;
      kind_q  <= req_i.data.kind;
      wval_q  <= req_i.data.write_value;
      last_q  <= req_i.data.run_end;
    end
    if (do_load) begin
      // writes and out of range items return zero
      out_q.read_value  <= (kind_q == bpas_pkg::KIND_READ && !err_q) ?
                           read_bits[WORD_BITS-1:0] : '0;
      out_q.index_error <= err_q;
      out_q.last_of_run <= last_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

/* design/bpas_checker.sv */
// port level checks of the bit packed array store, bound to the top level
module bpas_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [bpas_pkg::WORD_BITS-1:0] read_value_i,
  input logic                           index_error_i,
  input logic                           last_of_run_i
);

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // response held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(read_value_i) && $stable(index_error_i) && $stable(last_of_run_i))
    else $error("stalled response changed");

  // one request in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_ready_i)
    else $error("request accepted while previous one in flight");

  // with the output free at accept, the response shows once the modify state has loaded the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (!rsp_valid_i || rsp_ready_i) |-> ##2 rsp_valid_i)
    else $error("response late");

  // an out of range item never carries data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && index_error_i |-> read_value_i == '0)
    else $error("index error with nonzero read value");

endmodule

bind bit_packed_array_store_unit bpas_checker u_bpas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .read_value_i  (rsp_o.data.read_value),
  .index_error_i (rsp_o.data.index_error),
  .last_of_run_i (rsp_o.data.last_of_run)
);
